// File: hdl/mste_pkg.sv
// ----------------------------------------------------------------------------
// Timer engine package
// Shared widths, operation codes, controller states and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mste_pkg;

  localparam int unsigned OPCODE_W     = 3;
  localparam int unsigned SLOT_FIELD_W = 4;
  localparam int unsigned PERIOD_W     = 32;
  localparam int unsigned TIME_W       = 64;
  localparam int unsigned IN_TDATA_W   = 40;
  localparam int unsigned OUT_TDATA_W  = 8;

  localparam logic KIND_FIRE     = 1'b0;
  localparam logic KIND_MODE     = 1'b1;
  localparam logic MODE_PERIODIC = 1'b0;
  localparam logic MODE_ONESHOT  = 1'b1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK     = 3'd0,
    OP_CHECK    = 3'd1,
    OP_CREATE   = 3'd2,
    OP_RERUN    = 3'd3,
    OP_STOP     = 3'd4,
    OP_STOP_NOW = 3'd5
  } mste_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RERUN_RD,
    ST_RERUN_WR,
    ST_STOP,
    ST_SCAN,
    ST_FIRE_RD,
    ST_FIRE_WR
  } mste_state_e;

  typedef enum logic [1:0] {
    RD_SCAN,
    RD_ITEM,
    RD_BEST
  } mste_rdsel_e;

  typedef struct packed {
    logic        load;
    logic        tick;
    logic        create;
    logic        scan_init;
    logic        scan_first;
    logic        rerun_wr;
    logic        stop_wr;
    logic        fire_wr;
    mste_rdsel_e rd_sel;
  } mste_cmd_t;

  typedef struct packed {
    mste_op_e in_op;
    logic     in_slot_ok;
    logic     pass_end;
    logic     best_vld;
    logic     out_free;
    logic     fire_last;
  } mste_sts_t;

endpackage

`default_nettype wire

// File: hdl/mste_ctrl.sv
// ----------------------------------------------------------------------------
// Timer engine controller
// Sequences each operation: tick and create straight from idle, read-modify-write
// for rerun and stops, and repeated minimum-expiry scans for check.
// ----------------------------------------------------------------------------
`default_nettype none

module mste_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire mste_pkg::mste_sts_t sts_i,
  output mste_pkg::mste_cmd_t    cmd_o
);
  import mste_pkg::*;

  mste_state_e state_q, state_d;
  logic        accept;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (sts_i.in_op) inside
            OP_CHECK: state_d = ST_SCAN;
            OP_RERUN: state_d = sts_i.in_slot_ok ? ST_RERUN_RD : ST_IDLE;
            OP_STOP, OP_STOP_NOW: state_d = sts_i.in_slot_ok ? ST_STOP : ST_IDLE;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_RERUN_RD: state_d = ST_RERUN_WR;
      ST_RERUN_WR: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_STOP: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (sts_i.pass_end) begin
          state_d = sts_i.best_vld ? ST_FIRE_RD : ST_IDLE;
        end
      end
      ST_FIRE_RD: state_d = ST_FIRE_WR;
      ST_FIRE_WR: begin
        if (sts_i.out_free) begin
          state_d = sts_i.fire_last ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.rd_sel     = RD_SCAN;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.load       = accept;
        cmd_o.tick       = accept && (sts_i.in_op == OP_TICK);
        cmd_o.create     = accept && (sts_i.in_op == OP_CREATE) && sts_i.in_slot_ok;
        cmd_o.scan_init  = accept && (sts_i.in_op == OP_CHECK);
        cmd_o.scan_first = accept && (sts_i.in_op == OP_CHECK);
      end
      ST_RERUN_RD: cmd_o.rd_sel = RD_ITEM;
      ST_RERUN_WR: begin
        cmd_o.rd_sel   = RD_ITEM;
        cmd_o.rerun_wr = sts_i.out_free;
      end
      ST_STOP: cmd_o.stop_wr = sts_i.out_free;
      ST_SCAN: cmd_o.rd_sel = RD_SCAN;
      ST_FIRE_RD: cmd_o.rd_sel = RD_BEST;
      ST_FIRE_WR: begin
        cmd_o.rd_sel    = RD_BEST;
        cmd_o.fire_wr   = sts_i.out_free;
        // restart the search for the next pending slot
        cmd_o.scan_init = sts_i.out_free && !sts_i.fire_last;
      end
      default: cmd_o.rd_sel = RD_SCAN;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/mste_dp.sv
// ----------------------------------------------------------------------------
// Timer engine datapath
// Time count, slot flags, expiry and period memories, the minimum-expiry
// scan pipeline and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mste_dp #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire mste_pkg::mste_cmd_t               cmd_i,
  output mste_pkg::mste_sts_t                    sts_o,
  input  wire logic [mste_pkg::IN_TDATA_W-1:0]   in_tdata_i,
  input  wire logic [mste_pkg::OPCODE_W-1:0]     in_tuser_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [mste_pkg::OUT_TDATA_W-1:0]       out_tdata_o,
  output logic                                   out_tuser_o,
  output logic                                   out_last_o
);
  import mste_pkg::*;

  localparam int unsigned SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

  // Input fields
  logic [SLOT_FIELD_W-1:0] in_slot;
  logic [PERIOD_W-1:0]     in_period;
  logic                    in_mode;
  logic [SLOT_W-1:0]       in_idx;

  assign in_slot   = in_tdata_i[SLOT_FIELD_W-1:0];
  assign in_period = in_tdata_i[SLOT_FIELD_W +: PERIOD_W];
  assign in_mode   = in_tdata_i[SLOT_FIELD_W+PERIOD_W];
  assign in_idx    = SLOT_W'(in_slot);

  // State
  logic [TIME_W-1:0]    time_q;
  logic [NUM_SLOTS-1:0] armed_q, mode_q, pend_q;
  mste_op_e             item_op_q;
  logic [SLOT_W-1:0]    item_idx_q;
  logic                 item_mode_q;

  // Scan pipeline
  logic [SLOT_W-1:0]    scan_addr_q, dat_idx_q, best_q;
  logic                 issue_on_q, dat_vld_q, pass_end_q, first_q, best_vld_q;
  logic [TIME_W-1:0]    best_exp_q;

  // Memories
  logic [TIME_W-1:0]    exp_mem [NUM_SLOTS];
  logic [PERIOD_W-1:0]  per_mem [NUM_SLOTS];
  logic [TIME_W-1:0]    exp_rd_q;
  logic [PERIOD_W-1:0]  per_rd_q;
  logic [SLOT_W-1:0]    rd_addr;
  logic                 exp_we;
  logic [SLOT_W-1:0]    exp_wa;
  logic [TIME_W-1:0]    exp_wd;

  // Result register
  logic                    out_vld_q, out_kind_q, out_old_q, out_last_q;
  logic [SLOT_FIELD_W-1:0] out_slot_q;
  logic                    out_free, out_load;

  logic                 cand, better, fire_last;
  logic [NUM_SLOTS-1:0] pend_left;

  assign out_free = !out_vld_q || out_ready_i;
  assign out_load = cmd_i.rerun_wr || cmd_i.stop_wr || cmd_i.fire_wr;

  // First pass takes the eligible set; later passes use it
  always_comb begin
    cand = 1'b0;
    if (dat_vld_q) begin
      cand = first_q ? (armed_q[dat_idx_q] && (exp_rd_q <= time_q)) : pend_q[dat_idx_q];
    end
    better = cand && (!best_vld_q || (exp_rd_q < best_exp_q));
  end

  always_comb begin
    pend_left         = pend_q;
    pend_left[best_q] = 1'b0;
    fire_last         = ~|pend_left;
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RD_ITEM: rd_addr = item_idx_q;
      RD_BEST: rd_addr = best_q;
      default: rd_addr = scan_addr_q;
    endcase
  end

  always_comb begin
    exp_we = 1'b0;
    exp_wa = in_idx;
    exp_wd = time_q + TIME_W'(in_period);
    if (cmd_i.create) begin
      exp_we = 1'b1;
    end else if (cmd_i.rerun_wr) begin
      exp_we = 1'b1;
      exp_wa = item_idx_q;
      exp_wd = time_q + TIME_W'(per_rd_q);
    end else if (cmd_i.fire_wr && (mode_q[best_q] == MODE_PERIODIC)) begin
      exp_we = 1'b1;
      exp_wa = best_q;
      exp_wd = best_exp_q + TIME_W'(per_rd_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (exp_we) begin
      exp_mem[exp_wa] <= exp_wd;
    end
    exp_rd_q <= exp_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.create) begin
      per_mem[in_idx] <= in_period;
    end
    per_rd_q <= per_mem[rd_addr];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= '0;
      armed_q     <= '0;
      mode_q      <= '0;
      pend_q      <= '0;
      scan_addr_q <= '0;
      issue_on_q  <= 1'b0;
      dat_vld_q   <= 1'b0;
      pass_end_q  <= 1'b0;
      first_q     <= 1'b0;
      best_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      if (cmd_i.tick) begin
        time_q <= time_q + TIME_W'(1);
      end

      if (cmd_i.create) begin
        armed_q[in_idx] <= 1'b1;
        mode_q[in_idx]  <= in_mode;
      end
      if (cmd_i.rerun_wr) begin
        armed_q[item_idx_q] <= 1'b1;
        mode_q[item_idx_q]  <= item_mode_q;
      end
      if (cmd_i.stop_wr) begin
        mode_q[item_idx_q] <= MODE_ONESHOT;
        if (item_op_q == OP_STOP_NOW) begin
          armed_q[item_idx_q] <= 1'b0;
        end
      end
      if (cmd_i.fire_wr && (mode_q[best_q] == MODE_ONESHOT)) begin
        armed_q[best_q] <= 1'b0;
      end

      // Address issue, one slot a cycle
      if (cmd_i.scan_init) begin
        scan_addr_q <= '0;
        issue_on_q  <= 1'b1;
      end else if (issue_on_q) begin
        scan_addr_q <= scan_addr_q + SLOT_W'(1);
        if (scan_addr_q == LAST_IDX) begin
          issue_on_q <= 1'b0;
        end
      end
      dat_vld_q  <= issue_on_q && !cmd_i.scan_init;
      pass_end_q <= dat_vld_q && (dat_idx_q == LAST_IDX);

      if (cmd_i.fire_wr) begin
        first_q <= 1'b0;
      end else if (cmd_i.scan_first) begin
        first_q <= 1'b1;
      end

      if (cmd_i.fire_wr) begin
        pend_q <= pend_left;
      end else if (dat_vld_q && first_q) begin
        pend_q[dat_idx_q] <= cand;
      end

      if (cmd_i.scan_init) begin
        best_vld_q <= 1'b0;
      end else if (better) begin
        best_vld_q <= 1'b1;
      end

      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_op_q   <= mste_op_e'(in_tuser_i);
      item_idx_q  <= in_idx;
      item_mode_q <= in_mode;
    end
    dat_idx_q <= scan_addr_q;
    if (better) begin
      best_q     <= dat_idx_q;
      best_exp_q <= exp_rd_q;
    end
    if (out_load) begin
      out_kind_q <= cmd_i.fire_wr ? KIND_FIRE : KIND_MODE;
      out_slot_q <= cmd_i.fire_wr ? SLOT_FIELD_W'(best_q) : SLOT_FIELD_W'(item_idx_q);
      out_old_q  <= cmd_i.fire_wr ? 1'b0 : mode_q[item_idx_q];
      out_last_q <= cmd_i.fire_wr ? fire_last : 1'b1;
    end
  end

  assign sts_o.in_op      = mste_op_e'(in_tuser_i);
  assign sts_o.in_slot_ok = (32'(in_slot) < NUM_SLOTS);
  assign sts_o.pass_end   = pass_end_q;
  assign sts_o.best_vld   = best_vld_q;
  assign sts_o.out_free   = out_free;
  assign sts_o.fire_last  = fire_last;

  assign out_valid_o = out_vld_q;
  assign out_tdata_o = {{(OUT_TDATA_W-SLOT_FIELD_W-1){1'b0}}, out_old_q, out_slot_q};
  assign out_tuser_o = out_kind_q;
  assign out_last_o  = out_last_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result loaded over a pending transfer");

  a_fire_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fire_wr |-> best_vld_q)
    else $error("fire without a selected slot");

  a_oneshot_disarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fire_wr && mode_q[best_q]) |=> !armed_q[best_q])
    else $error("one-shot slot still armed after firing");

  a_pass_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pass_end_q |-> (!issue_on_q && !dat_vld_q))
    else $error("scan pass ended with reads in flight");

endmodule

`default_nettype wire

// File: hdl/multi_slot_software_timer_engine.sv
// ----------------------------------------------------------------------------
// Multi-slot software timer engine
// Timer slots with periodic or one-shot mode, a 64-bit tick count and a
// check operation that fires due slots in ascending expiry order.
// ----------------------------------------------------------------------------
// Tick and create act in the accept cycle and give no result; stop gives its
// result from the stop state, rerun after one expiry/period memory read.
// Check runs a scan pass over all slots, then a read and a write for the
// earliest due slot, and repeats until every due slot has fired. One item is in
// work at a time; a result held at the output stalls the next result, not the
// next input transfer. Reset clears time, armed and mode bits at once.
`default_nettype none

module multi_slot_software_timer_engine #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // slot [3:0], period [35:4], mode [36], zero [39:37]
  input  wire logic [mste_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // opcode [2:0]
  input  wire logic [mste_pkg::OPCODE_W-1:0]    s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // fired_slot [3:0], old_mode [4], zero [7:5]
  output logic [mste_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // kind [0]
  output logic                                  m_axis_tuser,
  output logic                                  m_axis_tlast
);
  import mste_pkg::*;

  mste_cmd_t cmd;
  mste_sts_t sts;

  mste_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mste_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_tdata_i  (s_axis_tdata),
    .in_tuser_i  (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_tdata_o (m_axis_tdata),
    .out_tuser_o (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Timer engine testbench
// Feeds tick, check, create, rerun and stop transfers to the timer engine and
// predicts every result from a local copy of the slot table. Both streams
// idle at random; the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mste_pkg::*;

  localparam int unsigned NUM_SLOTS    = 16;
  localparam int unsigned ITEMS        = 380;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned HOLD_AT      = 40;
  localparam int unsigned DRAIN_CYCLES = 400;

  localparam logic [OPCODE_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_RSVD_7 = 3'd7;

  typedef struct packed {
    logic [OPCODE_W-1:0]     op;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [PERIOD_W-1:0]     period;
    logic                    mode;
  } timer_cmd_t;

  typedef struct packed {
    logic                    kind;
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    old_mode;
    logic                    last;
  } timer_report_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [OPCODE_W-1:0]    s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;

  multi_slot_software_timer_engine #(
    .NUM_SLOTS(NUM_SLOTS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // Pending commands and the results they are predicted to cause
  timer_cmd_t    cmd_q [$];
  timer_report_t report_q [$];

  // Local copy of the slot table
  logic [TIME_W-1:0]   tick_count = '0;
  bit                  tmr_armed [NUM_SLOTS];
  logic [TIME_W-1:0]   tmr_expiry [NUM_SLOTS];
  logic [PERIOD_W-1:0] tmr_period [NUM_SLOTS];
  logic                tmr_mode [NUM_SLOTS];

  // Slots created so far, so a rerun never reads an unwritten period
  bit          made [NUM_SLOTS];
  int unsigned n_gen = 0;
  int unsigned n_items = 0;
  int unsigned n_acc = 0;
  int unsigned n_rx = 0;
  int unsigned n_err = 0;

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tmr_armed[i] = 1'b0;
      tmr_mode[i]  = MODE_PERIODIC;
    end
  end

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic timer_apply(input timer_cmd_t c);
    bit            due [NUM_SLOTS];
    int            best;
    int            fired [$];
    timer_report_t r;
    begin
      case (c.op) inside
        OP_TICK: tick_count = tick_count + TIME_W'(1);
        OP_CHECK: begin
          // Take the due set first, then fire by expiry, lower slot on ties
          for (int i = 0; i < NUM_SLOTS; i++) begin
            due[i] = tmr_armed[i] && (tmr_expiry[i] <= tick_count);
          end
          best = 0;
          while (best >= 0) begin
            best = -1;
            for (int i = 0; i < NUM_SLOTS; i++) begin
              if (due[i] && (best < 0 || tmr_expiry[i] < tmr_expiry[best])) best = i;
            end
            if (best >= 0) begin
              due[best] = 1'b0;
              if (tmr_mode[best] == MODE_PERIODIC) begin
                tmr_expiry[best] = tmr_expiry[best] + TIME_W'(tmr_period[best]);
              end else begin
                tmr_armed[best] = 1'b0;
              end
              fired.push_back(best);
            end
          end
          foreach (fired[k]) begin
            r.kind     = KIND_FIRE;
            r.slot     = SLOT_FIELD_W'(fired[k]);
            r.old_mode = MODE_PERIODIC;
            r.last     = (k == fired.size() - 1);
            report_q.push_back(r);
          end
        end
        OP_CREATE: begin
          tmr_period[c.slot] = c.period;
          tmr_mode[c.slot]   = c.mode;
          tmr_expiry[c.slot] = tick_count + TIME_W'(c.period);
          tmr_armed[c.slot]  = 1'b1;
        end
        OP_RERUN, OP_STOP, OP_STOP_NOW: begin
          r.kind     = KIND_MODE;
          r.slot     = c.slot;
          r.old_mode = tmr_mode[c.slot];
          r.last     = 1'b1;
          report_q.push_back(r);
          if (c.op == OP_RERUN) begin
            tmr_expiry[c.slot] = tick_count + TIME_W'(tmr_period[c.slot]);
            tmr_armed[c.slot]  = 1'b1;
            tmr_mode[c.slot]   = c.mode;
          end else begin
            tmr_mode[c.slot] = MODE_ONESHOT;
            if (c.op == OP_STOP_NOW) tmr_armed[c.slot] = 1'b0;
          end
        end
        default: ;  // reserved opcodes leave the table alone
      endcase
    end
  endtask

  // Sender: one command per transfer, random gap after each
  timer_cmd_t  tx_cur;
  int unsigned tx_gap;
  bit          tx_quiet = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      tx_gap        <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        timer_apply(tx_cur);
        n_acc++;
        if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap != 0) begin
          tx_gap        <= tx_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          tx_cur = cmd_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= tx_cur.op;
          s_axis_tdata  <= {3'b000, tx_cur.mode, tx_cur.period, tx_cur.slot};
          tx_gap        <= tx_quiet ? 0 : $urandom_range(0, 14);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void field_check(input string what, input logic [3:0] want,
                                      input logic [3:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      n_err++;
    end
  endfunction

  // Receiver: random hold-off per result, one long hold early in the run
  int unsigned   rx_gap;
  int unsigned   rx_next;
  bit            rx_quiet = 1'b0;
  timer_report_t rx_want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_gap        <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (report_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d slot %0d mode %0d last %0d",
                 $time, m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[4], m_axis_tlast);
        n_err++;
      end else begin
        rx_want = report_q.pop_front();
        field_check("kind", 4'(rx_want.kind), 4'(m_axis_tuser));
        field_check("slot", rx_want.slot, m_axis_tdata[3:0]);
        field_check("old_mode", 4'(rx_want.old_mode), 4'(m_axis_tdata[4]));
        field_check("last", 4'(rx_want.last), 4'(m_axis_tlast));
      end
      n_rx++;
      if ($urandom_range(0, 29) == 0) rx_quiet = !rx_quiet;
      rx_next = (n_rx == HOLD_AT) ? LONG_HOLD : (rx_quiet ? 0 : $urandom_range(0, 14));
      if (rx_next != 0) begin
        m_axis_tready <= 1'b0;
        rx_gap        <= rx_next - 1;
      end
    end else if (!m_axis_tready) begin
      if (rx_gap == 0) m_axis_tready <= 1'b1;
      else rx_gap <= rx_gap - 1;
    end
  end

  task automatic push_cmd(input logic [OPCODE_W-1:0] op, input logic [SLOT_FIELD_W-1:0] slot,
                          input logic [PERIOD_W-1:0] period, input logic mode);
    timer_cmd_t c;
    begin
      c.op     = op;
      c.slot   = slot;
      c.period = period;
      c.mode   = mode;
      cmd_q.push_back(c);
      n_gen++;
      if (op <= OP_STOP_NOW) n_items++;
      if (op == OP_CREATE) made[slot] = 1'b1;
    end
  endtask

  // Tick and check carry random unused fields
  task automatic push_bare(input logic [OPCODE_W-1:0] op);
    push_cmd(op, SLOT_FIELD_W'($urandom), $urandom, 1'($urandom));
  endtask

  initial begin
    int unsigned s;

    // Directed: empty check, stops on fresh slots, ties, period zero, max period
    push_bare(OP_CHECK);
    push_cmd(OP_STOP, 4'd3, '0, 1'b0);
    push_cmd(OP_STOP_NOW, 4'd15, '0, 1'b0);
    push_cmd(OP_CREATE, 4'd0, 32'd0, MODE_PERIODIC);
    push_cmd(OP_CREATE, 4'd15, 32'hFFFF_FFFF, MODE_ONESHOT);
    push_cmd(OP_CREATE, 4'd5, 32'd2, MODE_ONESHOT);
    push_cmd(OP_CREATE, 4'd7, 32'd2, MODE_PERIODIC);
    push_bare(OP_CHECK);
    push_cmd(OP_TICK, 4'hF, 32'hFFFF_FFFF, 1'b1);
    push_cmd(OP_TICK, 4'h0, 32'h0, 1'b0);
    push_bare(OP_CHECK);
    push_cmd(OP_RERUN, 4'd5, 32'hFFFF_FFFF, MODE_PERIODIC);
    push_cmd(OP_RSVD_6, 4'hF, 32'hFFFF_FFFF, 1'b1);
    push_cmd(OP_RSVD_7, 4'hF, 32'hFFFF_FFFF, 1'b1);
    push_cmd(OP_STOP, 4'd7, '0, 1'b0);
    push_bare(OP_TICK);
    push_bare(OP_TICK);
    push_bare(OP_CHECK);
    push_cmd(OP_STOP_NOW, 4'd0, '0, 1'b0);
    push_cmd(OP_CREATE, 4'd5, 32'd1, MODE_ONESHOT);
    push_cmd(OP_RERUN, 4'd15, '0, MODE_PERIODIC);
    push_bare(OP_TICK);
    push_bare(OP_CHECK);
    push_cmd(OP_STOP, 4'd15, '0, 1'b1);

    // Random: mostly arm-wait-check sequences, some control and noise
    while (n_items < ITEMS) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3: begin
          repeat ($urandom_range(1, 4)) begin
            push_cmd(OP_CREATE, SLOT_FIELD_W'($urandom_range(0, NUM_SLOTS - 1)),
                     PERIOD_W'($urandom_range(0, 6)), 1'($urandom_range(0, 1)));
          end
          repeat ($urandom_range(0, 5)) push_bare(OP_TICK);
          push_bare(OP_CHECK);
        end
        4: begin
          // arm every slot so one check fires them all
          if ($urandom_range(0, 2) == 0) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
              push_cmd(OP_CREATE, SLOT_FIELD_W'(i), PERIOD_W'($urandom_range(0, 3)),
                       1'($urandom_range(0, 1)));
            end
            repeat (3) push_bare(OP_TICK);
            push_bare(OP_CHECK);
          end
        end
        5, 6: begin
          s = $urandom_range(0, NUM_SLOTS - 1);
          case ($urandom_range(0, 2))
            0: if (made[s]) begin
              push_cmd(OP_RERUN, SLOT_FIELD_W'(s), $urandom, 1'($urandom_range(0, 1)));
            end
            1: push_cmd(OP_STOP, SLOT_FIELD_W'(s), $urandom, 1'($urandom));
            default: push_cmd(OP_STOP_NOW, SLOT_FIELD_W'(s), $urandom, 1'($urandom));
          endcase
        end
        7: push_cmd(OP_CREATE, SLOT_FIELD_W'($urandom_range(0, NUM_SLOTS - 1)), $urandom,
                    1'($urandom));
        8: begin
          repeat ($urandom_range(1, 6)) push_bare(OP_TICK);
          push_bare(OP_CHECK);
        end
        9: push_cmd($urandom_range(0, 1) ? OP_RSVD_6 : OP_RSVD_7, SLOT_FIELD_W'($urandom),
                    $urandom, 1'($urandom));
        10: push_bare(OP_CHECK);
        default: begin
          s = $urandom_range(0, NUM_SLOTS - 1);
          if (made[s]) begin
            push_cmd(OP_RERUN, SLOT_FIELD_W'(s), $urandom, 1'($urandom_range(0, 1)));
            repeat ($urandom_range(0, 4)) push_bare(OP_TICK);
            push_bare(OP_CHECK);
          end
        end
      endcase
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_acc != n_gen || report_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
